### rtl/core/gauss3x3_smoothing_filter_assert.svh
// Assertion macros for the 3x3 Gaussian smoothing filter.
// Included by the top level; needs no package.
`ifndef GAUSS3X3_SMOOTHING_FILTER_ASSERT_SVH
`define GAUSS3X3_SMOOTHING_FILTER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define G3SF_CHECK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("g3sf check failed");

// Condition in one cycle that forces a property in the next.
`define G3SF_CHECK_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("g3sf sequence check failed");

`endif

### rtl/core/g3sf_pkg.sv
// Shared types and constants of the 3x3 Gaussian smoothing filter.
// No dependencies.
package g3sf_pkg;

   // Q0.16 kernel weights (sigma 1, normalized)
   localparam logic [15:0] W_CORNER = 16'd4923;
   localparam logic [15:0] W_EDGE   = 16'd8116;
   localparam logic [15:0] W_CENTER = 16'd13381;

   localparam int unsigned FRAC_BITS  = 16;
   localparam int unsigned ROUND_BIAS = 32768;

   localparam int unsigned CFG_WIDTH_BITS  = 11;
   localparam int unsigned CFG_HEIGHT_BITS = 16;
   localparam int unsigned CSR_DATA_BITS   = 32;
   localparam int unsigned CSR_ADDR_BITS   = 3;

   localparam logic [CFG_WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd1024;

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } g3sf_reg_type;

   typedef struct packed {
      logic [CFG_WIDTH_BITS-1:0]  image_width;
      logic [CFG_HEIGHT_BITS-1:0] image_height;
      logic                       restart;
   } g3sf_cfg_type;

   typedef struct packed {
      logic row_done;
      logic frame_done;
   } g3sf_flags_type;

endpackage

### rtl/core/g3sf_req_if.sv
// Input pixel channel of the 3x3 Gaussian smoothing filter.
// Valid/ready handshake; no dependencies.
interface g3sf_req_if #(
   parameter int PIXEL_BITS = 16
) ();
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

### rtl/core/g3sf_rsp_if.sv
// Result channel of the 3x3 Gaussian smoothing filter.
// Valid/ready handshake; no dependencies.
interface g3sf_rsp_if #(
   parameter int PIXEL_BITS = 16
) ();
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] smoothed_pixel;
   logic                  row_done;
   logic                  frame_done;

   modport source (output valid, output smoothed_pixel, output row_done,
                   output frame_done, input ready);
   modport sink   (input valid, input smoothed_pixel, input row_done,
                   input frame_done, output ready);
endinterface

### rtl/core/g3sf_csr.sv
// APB-style register block: image width and height, frame restart pulse.
// Depends on g3sf_pkg.
module g3sf_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [g3sf_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [g3sf_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [g3sf_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                   csr_pready,
   output g3sf_pkg::g3sf_cfg_type                 cfg
);
   import g3sf_pkg::*;

   logic [CFG_WIDTH_BITS-1:0]  width_ff;
   logic [CFG_HEIGHT_BITS-1:0] height_ff;
   logic                       wr_en;
   g3sf_reg_type               reg_sel;

   assign csr_pready = 1'b1;
   // word index; byte lane bits are not decoded
   assign reg_sel    = g3sf_reg_type'(csr_paddr[2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[CFG_WIDTH_BITS-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[CFG_HEIGHT_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_BITS'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_BITS'(height_ff);
      endcase
   end

   // every register write restarts the frame
   assign cfg.image_width  = width_ff;
   assign cfg.image_height = height_ff;
   assign cfg.restart      = wr_en;

endmodule

### rtl/core/g3sf_line_mem.sv
// Single-port-write, single-port-read line store with registered read data.
// No dependencies.
module g3sf_line_mem #(
   parameter int DEPTH     = 1024,
   parameter int DATA_BITS = 32
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [DATA_BITS-1:0]         wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [DATA_BITS-1:0]         rd_data
);
   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/g3sf_kernel.sv
// Weighting, rounding and saturation of the 3x3 sums; drives the result channel.
// Depends on g3sf_pkg and g3sf_rsp_if.
module g3sf_kernel #(
   parameter int PIXEL_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [PIXEL_BITS+1:0]        corner_sum,
   input  logic [PIXEL_BITS+1:0]        edge_sum,
   input  logic [PIXEL_BITS-1:0]        center,
   input  g3sf_pkg::g3sf_flags_type     in_flags,
   g3sf_rsp_if.source                   rsp_chan
);
   import g3sf_pkg::*;

   localparam int PROD_BITS = PIXEL_BITS + 15;
   localparam int MID_BITS  = PIXEL_BITS + 14;
   localparam int ACC_BITS  = PIXEL_BITS + 17;

   logic                  p_valid_ff;
   logic [PROD_BITS-1:0]  p_corner_ff;
   logic [PROD_BITS-1:0]  p_edge_ff;
   logic [MID_BITS-1:0]   p_center_ff;
   g3sf_flags_type        p_flags_ff;

   logic                  out_valid_ff;
   logic [PIXEL_BITS-1:0] out_pixel_ff;
   g3sf_flags_type        out_flags_ff;

   logic                  out_free;
   logic                  p_free;
   logic [ACC_BITS-1:0]   acc;
   logic [PIXEL_BITS:0]   scaled;
   logic [PIXEL_BITS-1:0] pixel_in;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign p_free   = !p_valid_ff || out_free;
   assign in_ready = p_free;

   // product stage: constant multiplies, one per weight class
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (p_free) begin
         p_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (p_free && in_valid) begin
         p_corner_ff <= PROD_BITS'(corner_sum) * PROD_BITS'(W_CORNER);
         p_edge_ff   <= PROD_BITS'(edge_sum) * PROD_BITS'(W_EDGE);
         p_center_ff <= MID_BITS'(center) * MID_BITS'(W_CENTER);
         p_flags_ff  <= in_flags;
      end
   end

   // sum, round half up, drop the fraction, clamp to full scale
   always_comb begin
      acc = ACC_BITS'(p_corner_ff) + ACC_BITS'(p_edge_ff) + ACC_BITS'(p_center_ff)
          + ACC_BITS'(ROUND_BIAS);
      scaled = acc[ACC_BITS-1:FRAC_BITS];
      if (scaled[PIXEL_BITS]) begin
         pixel_in = '1;
      end else begin
         pixel_in = scaled[PIXEL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && p_valid_ff) begin
         out_pixel_ff <= pixel_in;
         out_flags_ff <= p_flags_ff;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.smoothed_pixel = out_pixel_ff;
   assign rsp_chan.row_done       = out_flags_ff.row_done;
   assign rsp_chan.frame_done     = out_flags_ff.frame_done;

endmodule

### rtl/core/gauss3x3_smoothing_filter.sv
// Top level of the 3x3 Gaussian smoothing filter (sigma 1).
// Depends on g3sf_pkg, g3sf_req_if, g3sf_rsp_if, g3sf_csr, g3sf_line_mem,
// g3sf_kernel and gauss3x3_smoothing_filter_assert.svh.
//
// Pixels enter in raster order at one transaction per clock while the result
// channel keeps taking results, and a filtered pixel leaves for every interior
// position (rows and columns other than the first and last). The result for
// the pixel completing a 3x3 window passes through the pipeline of input/read
// register, window/sum register, product register and output register before
// it shows up on the result channel. The ready path is the output register
// backing up through those stages, so the filter keeps taking pixels while a
// result waits, until those stages are full. The two previous rows sit in one
// line store of MAX_COLS words (upper and middle row side by side), read at the
// column of the incoming pixel and written back with the shifted column when
// that pixel leaves the input register; no clearing pass runs after reset and
// rows 0 and 1 of a frame produce no result, so unwritten entries never reach
// the output.
// Weights are Q0.16 (corner 4923, edge 8116, center 13381); results are
// rounded half up and clamped to full scale. row_done marks the last result
// of a row, frame_done the last result of a frame. Widths outside 3..MAX_COLS
// and heights below 3 are clamped. Any register write restarts the frame at
// row 0, column 0; write registers only while the pipeline is empty.
// Registers: image_width at byte 0, image_height at byte 4.
`include "gauss3x3_smoothing_filter_assert.svh"

module gauss3x3_smoothing_filter #(
   parameter int MAX_COLS   = 1024,
   parameter int PIXEL_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   g3sf_req_if.sink                            req_chan,
   g3sf_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [g3sf_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [g3sf_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [g3sf_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import g3sf_pkg::*;

   localparam int COL_BITS = $clog2(MAX_COLS);
   // wide enough for the width register and for MAX_COLS itself
   localparam int EW = (COL_BITS + 1 > CFG_WIDTH_BITS) ? COL_BITS + 1 : CFG_WIDTH_BITS;
   localparam int SUM_BITS = PIXEL_BITS + 2;

   g3sf_cfg_type cfg;

   g3sf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ---------------------------------------------------------------------
   // Effective frame geometry (clamped)
   // ---------------------------------------------------------------------
   logic [EW-1:0]              width_ext;
   logic [EW-1:0]              col_last;
   logic [CFG_HEIGHT_BITS-1:0] row_last;

   always_comb begin
      width_ext = EW'(cfg.image_width);
      if (width_ext < EW'(3)) begin
         col_last = EW'(2);
      end else if (width_ext > EW'(MAX_COLS)) begin
         col_last = EW'(MAX_COLS - 1);
      end else begin
         col_last = width_ext - EW'(1);
      end
      if (cfg.image_height < CFG_HEIGHT_BITS'(3)) begin
         row_last = CFG_HEIGHT_BITS'(2);
      end else begin
         row_last = cfg.image_height - CFG_HEIGHT_BITS'(1);
      end
   end

   // ---------------------------------------------------------------------
   // Handshake chain: A = input register, B = window/sum register
   // ---------------------------------------------------------------------
   logic a_valid_ff;
   logic b_valid_ff;
   logic k_ready;
   logic b_free;
   logic a_free;
   logic a_move;
   logic req_take;

   assign b_free   = !b_valid_ff || k_ready;
   assign a_free   = !a_valid_ff || b_free;
   assign a_move   = a_valid_ff && b_free;
   assign req_chan.ready = a_free;
   assign req_take = req_chan.valid && a_free;

   // ---------------------------------------------------------------------
   // Position counters (position of the next incoming pixel)
   // ---------------------------------------------------------------------
   logic [COL_BITS-1:0]        col_ff, col_in;
   logic [CFG_HEIGHT_BITS-1:0] row_ff, row_in;
   logic                       last_col;
   logic                       last_row;
   logic                       interior;

   assign last_col = (EW'(col_ff) == col_last);
   assign last_row = (row_ff == row_last);
   // window complete: at least two rows and two columns behind this pixel
   assign interior = (row_ff >= CFG_HEIGHT_BITS'(2)) && (col_ff >= COL_BITS'(2));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg.restart) begin
         col_in = '0;
         row_in = '0;
      end else if (req_take) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + CFG_HEIGHT_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------------
   // Line store: {upper row, middle row} per column
   // ---------------------------------------------------------------------
   logic [2*PIXEL_BITS-1:0] line_rd;
   logic [PIXEL_BITS-1:0]   top_px;
   logic [PIXEL_BITS-1:0]   mid_px;
   logic [COL_BITS-1:0]     a_col_ff;
   logic [PIXEL_BITS-1:0]   a_pix_ff;
   logic                    a_emit_ff;
   g3sf_flags_type          a_flags_ff;

   g3sf_line_mem #(
      .DEPTH     (MAX_COLS),
      .DATA_BITS (2 * PIXEL_BITS)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (a_move),
      .wr_addr (a_col_ff),
      .wr_data ({mid_px, a_pix_ff}),
      .rd_en   (req_take),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   assign top_px = line_rd[2*PIXEL_BITS-1:PIXEL_BITS];
   assign mid_px = line_rd[PIXEL_BITS-1:0];

   // stage A: incoming pixel alongside the line store read of its column
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_free) begin
         a_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_pix_ff              <= req_chan.pixel_in;
         a_col_ff              <= col_ff;
         a_emit_ff             <= interior;
         a_flags_ff.row_done   <= last_col;
         a_flags_ff.frame_done <= last_col && last_row;
      end
   end

   // ---------------------------------------------------------------------
   // Window: entries 0..2 column c-2, 3..5 column c-1 (top, middle, bottom)
   // ---------------------------------------------------------------------
   logic [PIXEL_BITS-1:0] win_ff [6];
   logic [SUM_BITS-1:0]   corner_in;
   logic [SUM_BITS-1:0]   edge_in;
   logic [SUM_BITS-1:0]   b_corner_ff;
   logic [SUM_BITS-1:0]   b_edge_ff;
   logic [PIXEL_BITS-1:0] b_center_ff;
   g3sf_flags_type        b_flags_ff;

   assign corner_in = SUM_BITS'(win_ff[0]) + SUM_BITS'(win_ff[2])
                    + SUM_BITS'(top_px) + SUM_BITS'(a_pix_ff);
   assign edge_in   = SUM_BITS'(win_ff[1]) + SUM_BITS'(win_ff[3])
                    + SUM_BITS'(win_ff[5]) + SUM_BITS'(mid_px);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (a_move) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_px;
         win_ff[4] <= mid_px;
         win_ff[5] <= a_pix_ff;
      end
   end

   // stage B only holds transactions that produce a result
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_free) begin
         b_valid_ff <= a_valid_ff && a_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         b_corner_ff <= corner_in;
         b_edge_ff   <= edge_in;
         b_center_ff <= win_ff[4];
         b_flags_ff  <= a_flags_ff;
      end
   end

   g3sf_kernel #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_kernel (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (b_valid_ff),
      .in_ready   (k_ready),
      .corner_sum (b_corner_ff),
      .edge_sum   (b_edge_ff),
      .center     (b_center_ff),
      .in_flags   (b_flags_ff),
      .rsp_chan   (rsp_chan)
   );

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   `G3SF_CHECK_NEXT(a_restart_zero, clock, reset, cfg.restart, (col_ff == '0) && (row_ff == '0))
   `G3SF_CHECK(a_col_in_range, clock, reset, EW'(col_ff) <= col_last)
   `G3SF_CHECK(a_row_in_range, clock, reset, row_ff <= row_last)

endmodule

### sim/gauss3x3_result_checker.sv
// Scoreboard for the 3x3 Gaussian smoothing filter: follows register writes
// and accepted pixels, predicts every smoothed pixel and checks each result.
// Depends on g3sf_pkg, g3sf_req_if and g3sf_rsp_if.
module gauss3x3_result_checker #(
   parameter int MAX_COLS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   g3sf_req_if                                 pixel_mon,
   g3sf_rsp_if                                 smooth_mon,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic                                csr_pready,
   input  logic [g3sf_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [g3sf_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output int unsigned                         failure_count,
   output int unsigned                         outstanding,
   output int unsigned                         smoothed_checked,
   output int unsigned                         frames_closed
);
   import g3sf_pkg::*;

   // Q0.16 kernel weights, sigma 1
   localparam int unsigned CORNER_Q16 = 4923;
   localparam int unsigned SIDE_Q16   = 8116;
   localparam int unsigned CENTER_Q16 = 13381;

   typedef struct packed {
      logic [15:0] smoothed_pixel;
      logic        row_done;
      logic        frame_done;
   } smoothed_result_type;

   logic [15:0]         row_above [MAX_COLS];   // row r-2
   logic [15:0]         row_prev  [MAX_COLS];   // row r-1
   logic [15:0]         window    [6];          // cols c-2 (0..2), c-1 (3..5): top, mid, bottom
   int unsigned         next_col;
   int unsigned         next_row;
   logic [10:0]         width_reg;
   logic [15:0]         height_reg;
   smoothed_result_type expected_smoothed [$];

   task automatic predict_smoothed(input logic [15:0] pixel);
      int unsigned         cols;
      int unsigned         rows;
      int unsigned         c;
      int unsigned         r;
      logic [15:0]         top;
      logic [15:0]         mid;
      bit [63:0]           corner_sum;
      bit [63:0]           side_sum;
      bit [63:0]           acc;
      bit [63:0]           rounded;
      smoothed_result_type res;
      cols = (width_reg < 3) ? 3 : ((width_reg > MAX_COLS) ? MAX_COLS : width_reg);
      rows = (height_reg < 3) ? 3 : height_reg;
      c = (next_col >= cols) ? cols - 1 : next_col;
      r = (next_row >= rows) ? rows - 1 : next_row;
      top = row_above[c];
      mid = row_prev[c];
      if (r >= 2 && c >= 2) begin
         corner_sum = 64'(window[0]) + window[2] + top + pixel;
         side_sum   = 64'(window[1]) + window[3] + window[5] + mid;
         acc = corner_sum * CORNER_Q16 + side_sum * SIDE_Q16 + 64'(window[4]) * CENTER_Q16;
         rounded = (acc + 64'd32768) >> 16;
         res.smoothed_pixel = (rounded > 64'hFFFF) ? 16'hFFFF : rounded[15:0];
         res.row_done   = (c == cols - 1);
         res.frame_done = (c == cols - 1) && (r == rows - 1);
         expected_smoothed.push_back(res);
      end
      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = top;
      window[4] = mid;
      window[5] = pixel;
      row_above[c] = mid;
      row_prev[c]  = pixel;
      if (c == cols - 1) begin
         next_col = 0;
         next_row = (r + 1 >= rows) ? 0 : r + 1;
      end else begin
         next_col = c + 1;
         next_row = r;
      end
   endtask

   always @(posedge clock) begin
      smoothed_result_type want;
      if (reset) begin
         width_reg  = 11'd1024;
         height_reg = 16'd1024;
         next_col   = 0;
         next_row   = 0;
         for (int i = 0; i < 6; i++) window[i] = '0;
         for (int i = 0; i < MAX_COLS; i++) begin
            row_above[i] = '0;
            row_prev[i]  = '0;
         end
         expected_smoothed.delete();
         failure_count    = 0;
         smoothed_checked = 0;
         frames_closed    = 0;
      end else begin
         // any register write restarts the frame
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[g3sf_pkg::CSR_ADDR_BITS-1:2])
               REG_IMAGE_WIDTH: begin
                  width_reg = csr_pwdata[10:0];
                  next_col  = 0;
                  next_row  = 0;
               end
               REG_IMAGE_HEIGHT: begin
                  height_reg = csr_pwdata[15:0];
                  next_col   = 0;
                  next_row   = 0;
               end
               default: ;
            endcase
         end
         if (pixel_mon.valid && pixel_mon.ready)
            predict_smoothed(pixel_mon.pixel_in);
         if (smooth_mon.valid && smooth_mon.ready) begin
            if (expected_smoothed.size() == 0) begin
               $error("smoothed pixel %0d arrived with no prediction pending",
                      smooth_mon.smoothed_pixel);
               failure_count++;
            end else begin
               want = expected_smoothed.pop_front();
               if (smooth_mon.smoothed_pixel !== want.smoothed_pixel) begin
                  $error("smoothed_pixel mismatch: expected %0d, actual %0d",
                         want.smoothed_pixel, smooth_mon.smoothed_pixel);
                  failure_count++;
               end
               if (smooth_mon.row_done !== want.row_done) begin
                  $error("row_done mismatch: expected %0b, actual %0b",
                         want.row_done, smooth_mon.row_done);
                  failure_count++;
               end
               if (smooth_mon.frame_done !== want.frame_done) begin
                  $error("frame_done mismatch: expected %0b, actual %0b",
                         want.frame_done, smooth_mon.frame_done);
                  failure_count++;
               end
               smoothed_checked++;
               if (want.frame_done) frames_closed++;
            end
         end
      end
      outstanding = expected_smoothed.size();
   end

endmodule

### sim/gauss3x3_smoothing_filter_tb.sv
// Top of the 3x3 Gaussian smoothing filter testbench: clock, reset, pixel
// and register stimulus, result back-pressure and the verdict.
// Depends on g3sf_pkg, the two channel interfaces, the filter and the checker.
module gauss3x3_smoothing_filter_tb;
   import g3sf_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 1_200_000;
   localparam int unsigned HOLD_CYCLES   = 400;   // long output stall, fills the pipeline
   localparam int unsigned DRAIN_CYCLES  = 12;    // pipeline is ~4 deep; margin on top
   localparam int unsigned RESET_PIXELS  = 40;    // part of row 0 only, no results
   localparam int unsigned CLAMP_PIXELS  = 40;
   localparam int unsigned STALL_WIDTH   = 32;
   localparam int unsigned STALL_HEIGHT  = 8;
   localparam int unsigned RANDOM_PIXELS = 640;

   typedef enum int unsigned {
      FILL_UNIFORM,
      FILL_EXTREMES,
      FILL_BRIGHT,
      FILL_RAMP
   } fill_style_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   g3sf_req_if pixel_bus ();
   g3sf_rsp_if smooth_bus ();

   int unsigned failure_count;
   int unsigned outstanding;
   int unsigned smoothed_checked;
   int unsigned frames_closed;
   int unsigned pixels_sent = 0;
   int unsigned settings_used = 0;
   int unsigned cycle_count;

   // bookkeeping of the register values last written, for sizing phases
   int unsigned cur_width = 1024;
   int unsigned cur_height = 1024;

   bit steady_flow = 1'b0;   // no idling on either side while set
   bit hold_output = 1'b0;   // receiver does one long stall when set

   always #5 clock = ~clock;

   gauss3x3_smoothing_filter dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (pixel_bus),
      .rsp_chan    (smooth_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // scoreboard sits beside the filter and only watches
   gauss3x3_result_checker scoreboard (
      .clock            (clock),
      .reset            (reset),
      .pixel_mon        (pixel_bus),
      .smooth_mon       (smooth_bus),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_pready       (csr_pready),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .failure_count    (failure_count),
      .outstanding      (outstanding),
      .smoothed_checked (smoothed_checked),
      .frames_closed    (frames_closed)
   );

   // Idle length: mostly none, often a short gap, now and then a long one.
   function automatic int unsigned idle_gap();
      int unsigned roll;
      if (steady_flow) return 0;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   function automatic logic [15:0] pick_pixel(fill_style_type style, int unsigned idx);
      logic [15:0] px;
      case (style)
         FILL_EXTREMES: px = $urandom_range(1) ? 16'hFFFF : 16'h0000;
         FILL_BRIGHT:   px = 16'hFFFF - 16'($urandom_range(255));   // pushes into saturation
         FILL_RAMP:     px = 16'(idx * 211 + $urandom_range(511));
         default:       px = 16'($urandom());
      endcase
      // sprinkle full-scale and black pixels into every pattern
      if ($urandom_range(99) < 6) px = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      return px;
   endfunction

   // APB write: setup, access, then an idle phase so back-to-back writes
   // never assign psel twice in one time step. Entered just after a negedge.
   task automatic write_register(input g3sf_reg_type which, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Writes width and/or height; upper data bits carry junk half the time
   // since the register only keeps its own field.
   task automatic set_frame_size(input int unsigned width, input int unsigned height,
                                 input bit write_width, input bit write_height);
      logic [31:0] data;
      if (write_width) begin
         data = $urandom_range(1) ? $urandom() : 32'd0;
         data[10:0] = width[10:0];
         write_register(REG_IMAGE_WIDTH, data);
         cur_width = width;
      end
      if (write_height) begin
         data = $urandom_range(1) ? $urandom() : 32'd0;
         data[15:0] = height[15:0];
         write_register(REG_IMAGE_HEIGHT, data);
         cur_height = height;
      end
      settings_used++;
   endtask

   // One pixel transaction. valid stays high across back-to-back pixels.
   task automatic send_pixel(input logic [15:0] px);
      int unsigned gap;
      gap = idle_gap();
      if (gap != 0) begin
         pixel_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      pixel_bus.valid    <= 1'b1;
      pixel_bus.pixel_in <= px;
      do @(posedge clock); while (!pixel_bus.ready);
      @(negedge clock);
      pixels_sent++;
   endtask

   task automatic stream_pixels(input int unsigned count, input fill_style_type style);
      for (int unsigned i = 0; i < count; i++) send_pixel(pick_pixel(style, i));
      pixel_bus.valid <= 1'b0;
   endtask

   // Sender pauses until every predicted result is out, then lets the
   // pipeline settle before any register write.
   task automatic drain_results();
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Result receiver: random back-pressure, plus one long hold on request.
   initial begin
      int unsigned gap;
      smooth_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_output) begin
            smooth_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_output = 1'b0;
         end else begin
            gap = idle_gap();
            if (gap != 0) begin
               smooth_bus.ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         smooth_bus.ready <= 1'b1;
         @(negedge clock);
      end
   end

   // Watchdog: a hung handshake or missing results end here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d results still pending", cycle_count, outstanding);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int unsigned    random_total;
      int unsigned    width;
      int unsigned    height;
      int unsigned    cols;
      int unsigned    rows;
      int unsigned    count;
      int unsigned    roll;
      fill_style_type style;

      pixel_bus.valid    = 1'b0;
      pixel_bus.pixel_in = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values: 1024x1024. A stretch of row 0 must give no result.
      settings_used++;
      stream_pixels(RESET_PIXELS, FILL_UNIFORM);
      drain_results();

      // Directed: smallest frame. All full scale saturates (weights sum to
      // slightly over unity); the second frame checks the wrap to row 0 and
      // a checkerboard of black and white.
      set_frame_size(3, 3, 1'b1, 1'b1);
      for (int i = 0; i < 9; i++) send_pixel(16'hFFFF);
      for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 16'hFFFF : 16'h0000);
      for (int i = 0; i < 6; i++) send_pixel(16'h0000);   // partial frame, cut by next write
      pixel_bus.valid <= 1'b0;
      drain_results();

      // Widest line: width field all ones clamps to the line store size,
      // height below 3 acts as 3. Only part of the first row is sent.
      set_frame_size(2047, 2, 1'b1, 1'b1);
      stream_pixels(CLAMP_PIXELS, FILL_EXTREMES);
      drain_results();

      // One full mid-size frame. The receiver stalls for a long stretch
      // while pixels keep coming, so the pipeline fills and holds off its
      // input.
      set_frame_size(STALL_WIDTH, STALL_HEIGHT, 1'b1, 1'b1);
      steady_flow = 1'b1;
      hold_output = 1'b1;
      stream_pixels(STALL_WIDTH * STALL_HEIGHT, FILL_UNIFORM);
      steady_flow = 1'b0;
      drain_results();

      // Random settings, mostly small frames so many frames complete.
      random_total = 0;
      while (random_total < RANDOM_PIXELS) begin
         roll = $urandom_range(99);
         if (roll < 12)      width = $urandom_range(2);        // clamps up to 3
         else if (roll < 20) width = 3;
         else                width = $urandom_range(40, 4);
         roll = $urandom_range(99);
         if (roll < 12)      height = $urandom_range(2);       // clamps up to 3
         else if (roll < 18) height = 65535;
         else if (roll < 22) height = $urandom_range(65535, 13);
         else                height = $urandom_range(10, 3);
         roll = $urandom_range(99);
         // a lone write still restarts the frame
         if (roll < 15)      set_frame_size(width, height, 1'b0, 1'b1);
         else if (roll < 30) set_frame_size(width, height, 1'b1, 1'b0);
         else                set_frame_size(width, height, 1'b1, 1'b1);

         cols = (cur_width < 3) ? 3 : ((cur_width > 1024) ? 1024 : cur_width);
         rows = (cur_height < 3) ? 3 : cur_height;
         if (rows > 12) count = cols * $urandom_range(6, 3) + $urandom_range(cols);
         else           count = cols * rows * $urandom_range(2, 1) + $urandom_range(2 * cols);
         // keep the total near the budget; a cut frame is restarted anyway
         if (count > RANDOM_PIXELS - random_total) count = RANDOM_PIXELS - random_total;

         steady_flow = ($urandom_range(4) == 0);
         style = fill_style_type'($urandom_range(3));
         stream_pixels(count, style);
         steady_flow = 1'b0;
         drain_results();
         random_total += count;
      end

      $display("Run covered %0d pixels over %0d frame size settings, 3-wide to clamped width.",
               pixels_sent, settings_used);
      $display("%0d smoothed pixels checked, %0d of them closing a frame.",
               smoothed_checked, frames_closed);
      if (failure_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### gauss3x3_smoothing_filter.f
+incdir+rtl/core
rtl/core/g3sf_pkg.sv
rtl/core/g3sf_req_if.sv
rtl/core/g3sf_rsp_if.sv
rtl/core/g3sf_csr.sv
rtl/core/g3sf_line_mem.sv
rtl/core/g3sf_kernel.sv
rtl/core/gauss3x3_smoothing_filter.sv
sim/gauss3x3_result_checker.sv
sim/gauss3x3_smoothing_filter_tb.sv
